>>> hw/rtl/wmhp_pkg.sv
`timescale 1ns / 1ps

package wmhp_pkg;

  localparam int unsigned MAX_FRAME_LEN = 16383;

  localparam logic [14:0] POS_SAT     = 15'h7FFF;
  localparam logic [15:0] MIN_LEN     = 16'd10;
  localparam logic [4:0]  HDR_SHORT   = 5'd24;
  localparam logic [4:0]  HDR_LONG    = 5'd30;
  localparam logic [15:0] FRAME_MAX   = 16'(MAX_FRAME_LEN);
  localparam logic [15:0] PAY_MAX     = 16'd16383;

  localparam logic [14:0] FC_POS      = 15'd0;
  localparam logic [14:0] DUR_POS     = 15'd2;
  localparam logic [14:0] SEQ_POS     = 15'd22;
  localparam logic [14:0] ADDR_BASE [4] = '{15'd4, 15'd10, 15'd16, 15'd24};

  localparam logic [1:0] TYPE_CTRL   = 2'd1;
  localparam logic [1:0] TYPE_DATA   = 2'd2;
  localparam logic [1:0] TYPE_RSVD   = 2'd3;
  localparam logic [3:0] SUB_DATA    = 4'd0;
  localparam logic [3:0] SUB_NULL    = 4'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_UNSUP  = 2'd2,
    ST_LONG   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [15:0] fc_word;
    logic [15:0] dur_word;
    logic [47:0] address_one;
    logic [47:0] address_two;
    logic [47:0] address_three;
    logic [47:0] address_four;
    logic [15:0] seq_word;
    logic [1:0]  status;
    logic [4:0]  header_length;
    logic [13:0] payload_length;
  } out_t;

endpackage

>>> hw/rtl/wifi_mac_header_parser.sv
`timescale 1ns / 1ps
// The result is registered and appears in the cycle after the transaction that carries frame_end.
// Throughput: one byte per cycle; the byte and the header fields are merged and
// classified in a single register-to-register pass.
// Input stalls only while a result waits and the output is stalled.
// Reset clears the byte position, the captured header fields and the output valid.

module wifi_mac_header_parser
  import wmhp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic [14:0] pos_q, pos_d;
  logic [15:0] fc_q, fc_d;
  logic [15:0] dur_q, dur_d;
  logic [15:0] seq_q, seq_d;
  logic [47:0] addr_q [4];
  logic [47:0] addr_d [4];
  logic        out_valid_q;
  out_t        out_q;
  out_t        res;

  logic        in_acc;
  logic        is_last;
  logic [15:0] len;
  logic [1:0]  ftype;
  logic [3:0]  fsub;
  logic        four;
  logic [4:0]  hl;
  logic [15:0] pay_full;
  status_e     st;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_last    = in_data_i.frame_end;

  always_comb begin
    fc_d  = fc_q;
    dur_d = dur_q;
    seq_d = seq_q;
    for (int k = 0; k < 4; k++) begin
      addr_d[k] = addr_q[k];
    end
    for (int i = 0; i < 2; i++) begin
      if (pos_q == FC_POS + 15'(i)) begin
        fc_d[8*i +: 8] = in_data_i.frame_byte;
      end
      if (pos_q == DUR_POS + 15'(i)) begin
        dur_d[8*i +: 8] = in_data_i.frame_byte;
      end
      if (pos_q == SEQ_POS + 15'(i)) begin
        seq_d[8*i +: 8] = in_data_i.frame_byte;
      end
    end
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 6; i++) begin
        if (pos_q == ADDR_BASE[k] + 15'(i)) begin
          addr_d[k][8*i +: 8] = in_data_i.frame_byte;
        end
      end
    end
    pos_d = (pos_q < POS_SAT) ? pos_q + 15'd1 : pos_q;
  end

  always_comb begin
    len   = {1'b0, pos_q} + 16'd1;
    ftype = fc_d[3:2];
    fsub  = fc_d[7:4];
    four  = (ftype == TYPE_DATA) && fc_d[8] && fc_d[9];
    hl    = four ? HDR_LONG : HDR_SHORT;

    if (len < MIN_LEN) begin
      st = ST_SHORT;
    end else if (ftype == TYPE_CTRL || ftype == TYPE_RSVD) begin
      st = ST_UNSUP;
    end else if (ftype == TYPE_DATA && fsub != SUB_DATA && fsub != SUB_NULL) begin
      st = ST_UNSUP;
    end else if (len < {11'd0, hl}) begin
      st = ST_SHORT;
    end else if (pos_q >= POS_SAT || len > FRAME_MAX) begin
      st = ST_LONG;
    end else begin
      st = ST_OK;
    end

    pay_full = len - {11'd0, hl};

    res.fc_word          = fc_d;
    res.dur_word         = dur_d;
    res.address_one      = addr_d[0];
    res.address_two      = addr_d[1];
    res.address_three    = addr_d[2];
    res.address_four     = four ? addr_d[3] : 48'd0;
    res.seq_word         = seq_d;
    res.status           = st;
    res.header_length    = (st == ST_OK) ? hl : 5'd0;
    if (st != ST_OK) begin
      res.payload_length = 14'd0;
    end else if (pay_full > PAY_MAX) begin
      res.payload_length = PAY_MAX[13:0];
    end else begin
      res.payload_length = pay_full[13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      fc_q  <= '0;
      dur_q <= '0;
      seq_q <= '0;
      for (int k = 0; k < 4; k++) begin
        addr_q[k] <= '0;
      end
    end else if (in_acc) begin
      if (is_last) begin
        pos_q <= '0;
        fc_q  <= '0;
        dur_q <= '0;
        seq_q <= '0;
        for (int k = 0; k < 4; k++) begin
          addr_q[k] <= '0;
        end
      end else begin
        pos_q <= pos_d;
        fc_q  <= fc_d;
        dur_q <= dur_d;
        seq_q <= seq_d;
        for (int k = 0; k < 4; k++) begin
          addr_q[k] <= addr_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && is_last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_last) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_rise_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && is_last))
    else $error("result appeared without a final byte");

  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_last) |=> (pos_q == '0 && fc_q == '0))
    else $error("frame state not cleared after final byte");

  a_ok_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_OK) |->
      (out_q.header_length == HDR_SHORT || out_q.header_length == HDR_LONG))
    else $error("successful result with bad header length");

  a_fail_pay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |->
      (out_q.payload_length == 14'd0 && out_q.header_length == 5'd0))
    else $error("failed result with nonzero lengths");

endmodule

>>> tb/sv/wmhp_header_check.sv
`timescale 1ns / 1ps

module wmhp_header_check
  import wmhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned SHOW_MAX = 10;

  logic [14:0] pos_q;
  logic [15:0] fc_q;
  logic [15:0] dur_q;
  logic [47:0] addr_q [4];
  logic [15:0] seq_q;
  out_t        header_q [$];

  function automatic void clear_header();
    pos_q = '0;
    fc_q  = '0;
    dur_q = '0;
    seq_q = '0;
    for (int i = 0; i < 4; i++) addr_q[i] = '0;
  endfunction

  function automatic void capture_byte(input logic [14:0] p, input logic [7:0] b);
    int unsigned pi;
    pi = p;
    if (pi < 2) begin
      fc_q[8*pi +: 8] = b;
    end else if (pi < 4) begin
      dur_q[8*(pi-2) +: 8] = b;
    end else if (pi < 22) begin
      addr_q[(pi-4)/6][8*((pi-4)%6) +: 8] = b;
    end else if (pi < 24) begin
      seq_q[8*(pi-22) +: 8] = b;
    end else if (pi < 30) begin
      addr_q[3][8*(pi-24) +: 8] = b;
    end
  endfunction

  function automatic out_t header_report();
    out_t        r;
    logic [15:0] len;
    logic [1:0]  ftype;
    logic [3:0]  sub;
    logic        four;
    logic [4:0]  hl;
    status_e     st;
    len   = 16'(pos_q) + 16'd1;
    ftype = fc_q[3:2];
    sub   = fc_q[7:4];
    four  = (ftype == TYPE_DATA) && fc_q[8] && fc_q[9];
    hl    = four ? HDR_LONG : HDR_SHORT;
    if (len < MIN_LEN) begin
      st = ST_SHORT;
    end else if (ftype == TYPE_CTRL || ftype == TYPE_RSVD) begin
      st = ST_UNSUP;
    end else if (ftype == TYPE_DATA && sub != SUB_DATA && sub != SUB_NULL) begin
      st = ST_UNSUP;
    end else if (len < 16'(hl)) begin
      st = ST_SHORT;
    end else if (pos_q >= POS_SAT || len > FRAME_MAX) begin
      st = ST_LONG;
    end else begin
      st = ST_OK;
    end
    r.fc_word          = fc_q;
    r.dur_word         = dur_q;
    r.address_one      = addr_q[0];
    r.address_two      = addr_q[1];
    r.address_three    = addr_q[2];
    r.address_four     = four ? addr_q[3] : '0;
    r.seq_word         = seq_q;
    r.status           = st;
    r.header_length    = (st == ST_OK) ? hl : 5'd0;
    r.payload_length   = '0;
    if (st == ST_OK) begin
      r.payload_length = ((len - 16'(hl)) > PAY_MAX) ? 14'(PAY_MAX) : 14'(len - 16'(hl));
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [47:0] got,
                             input logic [47:0] want);
    if (got !== want) begin
      if (fail_count_o < SHOW_MAX)
        $display("%t mismatch in %s: expected %h, actual %h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      clear_header();
      header_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (header_q.size() == 0) begin
          if (fail_count_o < SHOW_MAX)
            $display("%t header report with no frame outstanding: %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = header_q.pop_front();
          check_field("fc_word", out_data_i.fc_word, want.fc_word);
          check_field("dur_word", out_data_i.dur_word, want.dur_word);
          check_field("address_one", out_data_i.address_one, want.address_one);
          check_field("address_two", out_data_i.address_two, want.address_two);
          check_field("address_three", out_data_i.address_three, want.address_three);
          check_field("address_four", out_data_i.address_four, want.address_four);
          check_field("seq_word", out_data_i.seq_word, want.seq_word);
          check_field("status", out_data_i.status, want.status);
          check_field("header_length", out_data_i.header_length, want.header_length);
          check_field("payload_length", out_data_i.payload_length, want.payload_length);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        capture_byte(pos_q, in_data_i.frame_byte);
        if (in_data_i.frame_end) begin
          header_q.push_back(header_report());
          clear_header();
        end else if (pos_q != POS_SAT) begin
          pos_q++;
        end
      end
      pending_o = header_q.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wmhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_BYTES = 1750;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int          FILL_RANDOM  = -1;

  localparam logic [1:0] TYPE_MGMT  = 2'd0;
  localparam logic [3:0] SUB_BEACON = 4'd8;
  localparam logic [3:0] SUB_ACK    = 4'd13;
  localparam logic [3:0] SUB_QOS    = 4'd8;
  localparam logic [7:0] NO_FLAGS   = 8'h00;
  localparam logic [7:0] TO_DS      = 8'h01;
  localparam logic [7:0] FROM_DS    = 8'h02;
  localparam logic [7:0] ALL_FLAGS  = 8'hFF;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles     = 0;
  int unsigned bytes_sent = 0;
  bit          hold_req   = 1'b0;
  bit          calm_tx    = 1'b0;

  always #2 clk = ~clk;

  wifi_mac_header_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  wmhp_header_check header_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [15:0] make_fc(input logic [1:0] ftype, input logic [3:0] sub,
                                          input logic [7:0] flags);
    return {flags, sub, ftype, 2'b00};
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last, input bit quiet);
    int unsigned idle;
    in_t         item;
    idle = (quiet || calm_tx) ? 0 : gap_len();
    item.frame_byte = b;
    item.frame_end  = last;
    @(negedge clk);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input logic [15:0] fc, input int fill,
                            input bit quiet);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if (i < 2) b = fc[8*i +: 8];
      else if (fill < 0) b = 8'($urandom);
      else b = 8'(fill);
      push_byte(b, i == len - 1, quiet);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic random_frame();
    int unsigned r;
    int unsigned len;
    logic [15:0] fc;
    logic [7:0]  flags;
    r       = $urandom_range(0, 99);
    flags   = 8'($urandom);
    calm_tx = ($urandom_range(0, 4) == 0);
    len     = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 31) : $urandom_range(24, 96);
    if (r < 35) begin
      fc = make_fc(TYPE_MGMT, 4'($urandom), flags);
    end else if (r < 75) begin
      fc = make_fc(TYPE_DATA, $urandom_range(0, 1) ? SUB_NULL : SUB_DATA, flags);
    end else if (r < 85) begin
      fc  = 16'($urandom);
      len = $urandom_range(1, 12);
    end else begin
      fc  = 16'($urandom);
      len = $urandom_range(1, 60);
    end
    fc[1:0] = 2'($urandom);
    send_frame(len, fc, FILL_RANDOM, 1'b0);
  endtask

  initial begin : receiver
    int unsigned n;
    int unsigned mode_left;
    bit          calm;
    mode_left = 0;
    calm      = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else if (calm) begin
        n = 0;
      end else begin
        n = gap_len();
      end
      if (n == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned fnum;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    send_frame(1, make_fc(TYPE_MGMT, SUB_BEACON, NO_FLAGS), FILL_RANDOM, 1'b0);
    send_frame(9, 16'hFFFF, 8'hFF, 1'b0);
    send_frame(10, make_fc(TYPE_CTRL, SUB_ACK, NO_FLAGS), FILL_RANDOM, 1'b0);
    send_frame(10, make_fc(TYPE_MGMT, SUB_BEACON, NO_FLAGS), FILL_RANDOM, 1'b0);
    send_frame(23, make_fc(TYPE_MGMT, SUB_BEACON, NO_FLAGS), 8'h00, 1'b0);
    send_frame(24, make_fc(TYPE_MGMT, SUB_BEACON, NO_FLAGS), 8'hFF, 1'b0);
    send_frame(24, 16'h0000, 8'h00, 1'b0);
    send_frame(40, make_fc(TYPE_RSVD, SUB_DATA, NO_FLAGS), FILL_RANDOM, 1'b0);
    send_frame(30, make_fc(TYPE_DATA, SUB_QOS, NO_FLAGS), FILL_RANDOM, 1'b0);
    send_frame(24, make_fc(TYPE_DATA, SUB_DATA, NO_FLAGS), FILL_RANDOM, 1'b0);
    send_frame(24, make_fc(TYPE_DATA, SUB_NULL, TO_DS), FILL_RANDOM, 1'b0);
    send_frame(50, make_fc(TYPE_DATA, SUB_DATA, FROM_DS), FILL_RANDOM, 1'b0);
    send_frame(12, make_fc(TYPE_DATA, SUB_DATA, TO_DS | FROM_DS), FILL_RANDOM, 1'b0);
    send_frame(29, make_fc(TYPE_DATA, SUB_DATA, TO_DS | FROM_DS), FILL_RANDOM, 1'b0);
    send_frame(30, make_fc(TYPE_DATA, SUB_DATA, TO_DS | FROM_DS), FILL_RANDOM, 1'b0);
    send_frame(30, make_fc(TYPE_DATA, SUB_NULL, TO_DS | FROM_DS), 8'hFF, 1'b0);
    send_frame(64, make_fc(TYPE_DATA, SUB_DATA, TO_DS | FROM_DS), FILL_RANDOM, 1'b0);
    send_frame(40, make_fc(TYPE_MGMT, 4'hF, ALL_FLAGS) | 16'h0003, FILL_RANDOM, 1'b0);
    send_frame(30, make_fc(TYPE_DATA, SUB_QOS, TO_DS | FROM_DS), FILL_RANDOM, 1'b0);
    send_frame(26, make_fc(TYPE_CTRL, SUB_ACK, TO_DS | FROM_DS), FILL_RANDOM, 1'b0);

    fnum = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (fnum == 5) begin
        // hold the output while short frames pile up behind the first report
        hold_req = 1'b1;
        repeat (4) send_frame($urandom_range(10, 12), 16'($urandom), FILL_RANDOM, 1'b1);
      end
      if (fnum == 12) drain();
      random_frame();
      fnum++;
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
